FILE: sv/tvsz_pkg.sv
package tvsz_pkg;

  // field widths
  localparam int VIEW_W   = 12;
  localparam int TILE_W   = 10;
  localparam int POS_W    = 18;
  localparam int RECT_W   = 24;
  localparam int SIZE_W   = 12;
  localparam int OFF_W    = 24;
  localparam int SCROLL_W = 23;
  localparam int MAP_PX_W = TILE_W + VIEW_W;
  localparam int PROD_W   = POS_W + VIEW_W;

  localparam int FRAC_BITS = 8;
  localparam int ZOOM_STEP = 2;
  localparam int INIT_COLS = 17;
  localparam int INIT_ROWS = 13;

  // register reset values
  localparam logic [VIEW_W-1:0] VIEW_W_RST   = 12'd640;
  localparam logic [VIEW_W-1:0] VIEW_H_RST   = 12'd480;
  localparam logic [TILE_W-1:0] MAP_COLS_RST = 10'd100;
  localparam logic [TILE_W-1:0] MAP_ROWS_RST = 10'd100;
  localparam logic [TILE_W-1:0] MIN_COLS_RST = 10'd5;
  localparam logic [TILE_W-1:0] MIN_ROWS_RST = 10'd5;
  localparam logic [TILE_W-1:0] MAX_COLS_RST = 10'd40;
  localparam logic [TILE_W-1:0] MAX_ROWS_RST = 10'd30;

  localparam int CELL_W_DIV = 640 / INIT_COLS;
  localparam int CELL_H_DIV = 480 / INIT_ROWS;
  localparam logic [SIZE_W-1:0] CELL_W_RST = SIZE_W'((CELL_W_DIV < 1) ? 1 : CELL_W_DIV);
  localparam logic [SIZE_W-1:0] CELL_H_RST = SIZE_W'((CELL_H_DIV < 1) ? 1 : CELL_H_DIV);
  localparam logic [TILE_W-1:0] COLS_RST   = TILE_W'(INIT_COLS);
  localparam logic [TILE_W-1:0] ROWS_RST   = TILE_W'(INIT_ROWS);

  // operation codes
  localparam logic [2:0] OP_CENTRE   = 3'd0;
  localparam logic [2:0] OP_ZOOM_IN  = 3'd1;
  localparam logic [2:0] OP_ZOOM_OUT = 3'd2;
  localparam logic [2:0] OP_TILE     = 3'd3;
  localparam logic [2:0] OP_RECT     = 3'd4;

  // register indexes
  localparam logic [2:0] REG_VIEW_W   = 3'd0;
  localparam logic [2:0] REG_VIEW_H   = 3'd1;
  localparam logic [2:0] REG_MAP_COLS = 3'd2;
  localparam logic [2:0] REG_MAP_ROWS = 3'd3;
  localparam logic [2:0] REG_MIN_COLS = 3'd4;
  localparam logic [2:0] REG_MIN_ROWS = 3'd5;
  localparam logic [2:0] REG_MAX_COLS = 3'd6;
  localparam logic [2:0] REG_MAX_ROWS = 3'd7;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 120;

  typedef struct packed {
    logic [VIEW_W-1:0] view_w;
    logic [VIEW_W-1:0] view_h;
    logic [TILE_W-1:0] map_cols;
    logic [TILE_W-1:0] map_rows;
    logic [TILE_W-1:0] min_cols;
    logic [TILE_W-1:0] min_rows;
    logic [TILE_W-1:0] max_cols;
    logic [TILE_W-1:0] max_rows;
  } cfg_t;

endpackage

FILE: sv/tvsz_div.sv
module tvsz_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tvsz_pkg::VIEW_W-1:0]    dividend,
  input  logic [tvsz_pkg::TILE_W-1:0]    divisor,
  output logic [tvsz_pkg::VIEW_W-1:0]    quotient,
  output logic                           done
);

  localparam int STEPS = tvsz_pkg::VIEW_W;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int DW    = tvsz_pkg::TILE_W;

  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [tvsz_pkg::VIEW_W-1:0]      quo_r, quo_nxt;
  logic [DW-1:0]                    rem_r, rem_nxt;
  logic [DW-1:0]                    dvs_r, dvs_nxt;
  logic                             done_r, done_nxt;
  logic [DW:0]                      shifted;
  logic [DW+1:0]                    trial;
  logic                             ge;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    shifted  = {rem_r, quo_r[tvsz_pkg::VIEW_W-1]};
    trial    = {1'b0, shifted} - {2'b00, dvs_r};
    ge       = !trial[DW+1];
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = CNT_W'(STEPS);
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? trial[DW-1:0] : shifted[DW-1:0];
      quo_nxt  = {quo_r[tvsz_pkg::VIEW_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

FILE: sv/tvsz_regs.sv
module tvsz_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tvsz_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tvsz_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tvsz_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output tvsz_pkg::cfg_t                     cfg,
  output logic                               wr_stb
);

  tvsz_pkg::cfg_t cfg_r, cfg_nxt;
  logic [2:0]     idx;
  logic           wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign wr_stb = wr;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        tvsz_pkg::REG_VIEW_W:   cfg_nxt.view_w   = pwdata[tvsz_pkg::VIEW_W-1:0];
        tvsz_pkg::REG_VIEW_H:   cfg_nxt.view_h   = pwdata[tvsz_pkg::VIEW_W-1:0];
        tvsz_pkg::REG_MAP_COLS: cfg_nxt.map_cols = pwdata[tvsz_pkg::TILE_W-1:0];
        tvsz_pkg::REG_MAP_ROWS: cfg_nxt.map_rows = pwdata[tvsz_pkg::TILE_W-1:0];
        tvsz_pkg::REG_MIN_COLS: cfg_nxt.min_cols = pwdata[tvsz_pkg::TILE_W-1:0];
        tvsz_pkg::REG_MIN_ROWS: cfg_nxt.min_rows = pwdata[tvsz_pkg::TILE_W-1:0];
        tvsz_pkg::REG_MAX_COLS: cfg_nxt.max_cols = pwdata[tvsz_pkg::TILE_W-1:0];
        tvsz_pkg::REG_MAX_ROWS: cfg_nxt.max_rows = pwdata[tvsz_pkg::TILE_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tvsz_pkg::REG_VIEW_W:   prdata = 32'(cfg_r.view_w);
      tvsz_pkg::REG_VIEW_H:   prdata = 32'(cfg_r.view_h);
      tvsz_pkg::REG_MAP_COLS: prdata = 32'(cfg_r.map_cols);
      tvsz_pkg::REG_MAP_ROWS: prdata = 32'(cfg_r.map_rows);
      tvsz_pkg::REG_MIN_COLS: prdata = 32'(cfg_r.min_cols);
      tvsz_pkg::REG_MIN_ROWS: prdata = 32'(cfg_r.min_rows);
      tvsz_pkg::REG_MAX_COLS: prdata = 32'(cfg_r.max_cols);
      tvsz_pkg::REG_MAX_ROWS: prdata = 32'(cfg_r.max_rows);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.view_w   <= tvsz_pkg::VIEW_W_RST;
      cfg_r.view_h   <= tvsz_pkg::VIEW_H_RST;
      cfg_r.map_cols <= tvsz_pkg::MAP_COLS_RST;
      cfg_r.map_rows <= tvsz_pkg::MAP_ROWS_RST;
      cfg_r.min_cols <= tvsz_pkg::MIN_COLS_RST;
      cfg_r.min_rows <= tvsz_pkg::MIN_ROWS_RST;
      cfg_r.max_cols <= tvsz_pkg::MAX_COLS_RST;
      cfg_r.max_rows <= tvsz_pkg::MAX_ROWS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: sv/tile_viewport_scroll_zoom.sv
// channel   direction  handshake                  payload
// in_       slave      in_tvalid / in_tready      in_tuser operation, in_tdata position and rect
// out_      master     out_tvalid / out_tready    out_tdata scroll, cell, draw pos, visible
// cfg_      apb slave  psel, penable, pready=1    8 registers at byte address 4*i
//
// one item at a time; a shared divider and a shared 18x12 multiplier under a sequencer
// set the latency
// centre: map, position and offset steps for x, then for y; tile query: x edge, y edge, finish;
// rectangle query and unused codes: straight to the result; zoom: two divides, one per axis
// a register write starts a cell recompute, in_tready low meanwhile
// reset is synchronous, active low; the result register lets the next item in while
// a beat waits on out_tready
module tile_viewport_scroll_zoom (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // pos_x[17:0], pos_y[35:18], rect_x[59:36], rect_y[83:60], rect_w[95:84],
  // rect_h[107:96], zero fill above
  input  logic [tvsz_pkg::IN_TDATA_W-1:0]       in_tdata,
  // operation[2:0]
  input  logic [2:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // scroll_x[22:0], scroll_y[45:23], cell_w[57:46], cell_h[69:58], draw_x[93:70],
  // draw_y[117:94], visible[118], zero fill above
  output logic [tvsz_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [tvsz_pkg::APB_ADDR_W-1:0]       cfg_paddr,
  input  logic [tvsz_pkg::APB_DATA_W-1:0]       cfg_pwdata,
  output logic [tvsz_pkg::APB_DATA_W-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int VW  = tvsz_pkg::VIEW_W;
  localparam int TW  = tvsz_pkg::TILE_W;
  localparam int PW  = tvsz_pkg::POS_W;
  localparam int OW  = tvsz_pkg::OFF_W;
  localparam int MPW = tvsz_pkg::MAP_PX_W;
  localparam int PRW = tvsz_pkg::PROD_W;
  localparam int FB  = tvsz_pkg::FRAC_BITS;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DIVW_GO  = 4'd1;
  localparam logic [3:0] S_DIVW     = 4'd2;
  localparam logic [3:0] S_DIVH_GO  = 4'd3;
  localparam logic [3:0] S_DIVH     = 4'd4;
  localparam logic [3:0] S_MAPX     = 4'd5;
  localparam logic [3:0] S_POSX     = 4'd6;
  localparam logic [3:0] S_OFFX     = 4'd7;
  localparam logic [3:0] S_MAPY     = 4'd8;
  localparam logic [3:0] S_POSY     = 4'd9;
  localparam logic [3:0] S_OFFY     = 4'd10;
  localparam logic [3:0] S_TILEX    = 4'd11;
  localparam logic [3:0] S_TILEY    = 4'd12;
  localparam logic [3:0] S_TILEF    = 4'd13;
  localparam logic [3:0] S_RESULT   = 4'd14;

  function automatic logic [TW-1:0] step_in(input logic [TW-1:0] n, input logic [TW-1:0] lo);
    logic signed [TW+1:0] t;
    t = $signed({2'b00, n}) - $signed((TW+2)'(tvsz_pkg::ZOOM_STEP));
    if (t < $signed({2'b00, lo})) t = $signed({2'b00, lo});
    if (t < $signed((TW+2)'(1))) t = $signed((TW+2)'(1));
    return t[TW-1:0];
  endfunction

  function automatic logic [TW-1:0] step_out(input logic [TW-1:0] n, input logic [TW-1:0] hi);
    logic [TW+1:0] t;
    t = {2'b00, n} + (TW+2)'(tvsz_pkg::ZOOM_STEP);
    if (t > {2'b00, hi}) t = {2'b00, hi};
    if (t < (TW+2)'(1)) t = (TW+2)'(1);
    return t[TW-1:0];
  endfunction

  // offset that puts a fractional tile position at the viewport middle
  function automatic logic signed [OW-1:0] centre_axis(input logic [VW-1:0] view,
                                                       input logic [VW-1:0] pitch,
                                                       input logic [MPW-1:0] map_px,
                                                       input logic [PRW-1:0] prod);
    logic [MPW-1:0]    diff;
    logic [PRW+1:0]    twice;
    logic signed [OW:0] des;
    logic signed [OW:0] lo;
    diff  = {{(MPW-VW){1'b0}}, view} - map_px;
    twice = {1'b0, prod, 1'b0} + ((PRW+2)'(pitch) << FB);
    des   = $signed((OW+1)'(view >> 1)) - $signed((OW+1)'(twice >> (FB + 1)));
    lo    = $signed((OW+1)'(view)) - $signed((OW+1)'(map_px));
    if (map_px <= {{(MPW-VW){1'b0}}, view}) return OW'(diff >> 1);
    if (des < lo) des = lo;
    if (des > $signed((OW+1)'(0))) des = '0;
    return des[OW-1:0];
  endfunction

  function automatic logic signed [OW-1:0] sat24(input logic signed [31:0] v);
    if (v > $signed(32'sd8388607)) return 24'h7FFFFF;
    if (v < $signed(-32'sd8388608)) return 24'h800000;
    return v[OW-1:0];
  endfunction

  tvsz_pkg::cfg_t cfg;
  logic           cfg_wr;

  tvsz_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg),
    .wr_stb  (cfg_wr)
  );

  logic           div_start;
  logic [VW-1:0]  div_dvd;
  logic [TW-1:0]  div_dvs;
  logic [VW-1:0]  div_quo;
  logic           div_done;

  tvsz_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .done     (div_done)
  );

  logic [3:0]             state_r, state_nxt;
  logic                   item_r, item_nxt;
  logic                   recalc_r, recalc_nxt;
  logic [TW-1:0]          cols_r, cols_nxt;
  logic [TW-1:0]          rows_r, rows_nxt;
  logic [VW-1:0]          cell_w_r, cell_w_nxt;
  logic [VW-1:0]          cell_h_r, cell_h_nxt;
  logic signed [OW-1:0]   off_x_r, off_x_nxt;
  logic signed [OW-1:0]   off_y_r, off_y_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [tvsz_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [PW-1:0]          pos_x_r, pos_x_nxt;
  logic [PW-1:0]          pos_y_r, pos_y_nxt;
  logic [MPW-1:0]         map_px_r, map_px_nxt;
  logic [PRW-1:0]         mul_r;
  logic signed [OW-1:0]   sx_r, sx_nxt;
  logic signed [OW-1:0]   sy_r, sy_nxt;
  logic                   vis_x_r, vis_x_nxt;
  logic                   vis_r, vis_nxt;

  logic [PW-1:0]          mul_a;
  logic [VW-1:0]          mul_b;
  logic [2:0]             in_op;
  logic signed [tvsz_pkg::RECT_W-1:0] rect_x, rect_y;
  logic [VW-1:0]          rect_w, rect_h;
  logic                   rect_vis;
  logic signed [31:0]     tile_e;
  logic [VW-1:0]          tile_c;
  logic [VW-1:0]          tile_v;
  logic signed [OW-1:0]   tile_off;
  logic                   tile_vis;
  logic [VW-1:0]          cell_q;

  assign in_op  = in_tuser;
  assign rect_x = $signed(in_tdata[59:36]);
  assign rect_y = $signed(in_tdata[83:60]);
  assign rect_w = in_tdata[95:84];
  assign rect_h = in_tdata[107:96];

  assign rect_vis = ($signed({rect_x[23], rect_x}) + $signed({13'd0, rect_w}) > 25'sd0) &&
                    ($signed({rect_y[23], rect_y}) + $signed({13'd0, rect_h}) > 25'sd0) &&
                    (rect_x < $signed({12'd0, cfg.view_w})) &&
                    (rect_y < $signed({12'd0, cfg.view_h}));

  // tile edge for the axis whose product sits in mul_r
  assign tile_c   = (state_r == S_TILEY) ? cell_w_r : cell_h_r;
  assign tile_v   = (state_r == S_TILEY) ? cfg.view_w : cfg.view_h;
  assign tile_off = (state_r == S_TILEY) ? off_x_r : off_y_r;
  assign tile_e   = $signed({2'b00, mul_r}) + $signed({{(32-OW){tile_off[OW-1]}}, tile_off});
  assign tile_vis = (tile_e + $signed({20'd0, tile_c}) > 32'sd0) &&
                    (tile_e < $signed({20'd0, tile_v}));

  assign cell_q = (div_quo == '0) ? VW'(1) : div_quo;

  assign in_tready  = (state_r == S_IDLE) && !recalc_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    recalc_nxt    = recalc_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    cell_w_nxt    = cell_w_r;
    cell_h_nxt    = cell_h_r;
    off_x_nxt     = off_x_r;
    off_y_nxt     = off_y_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    map_px_nxt    = map_px_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    vis_x_nxt     = vis_x_r;
    vis_nxt       = vis_r;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_dvd       = cfg.view_w;
    div_dvs       = (cols_r == '0) ? TW'(1) : cols_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (recalc_r) begin
          recalc_nxt = 1'b0;
          item_nxt   = 1'b0;
          state_nxt  = S_DIVW_GO;
        end else if (in_tvalid) begin
          item_nxt  = 1'b1;
          pos_x_nxt = in_tdata[17:0];
          pos_y_nxt = in_tdata[35:18];
          sx_nxt    = '0;
          sy_nxt    = '0;
          vis_nxt   = 1'b0;
          case (in_op)
            tvsz_pkg::OP_CENTRE: state_nxt = S_MAPX;
            tvsz_pkg::OP_ZOOM_IN: begin
              cols_nxt  = step_in(cols_r, cfg.min_cols);
              rows_nxt  = step_in(rows_r, cfg.min_rows);
              state_nxt = S_DIVW_GO;
            end
            tvsz_pkg::OP_ZOOM_OUT: begin
              cols_nxt  = step_out(cols_r, cfg.max_cols);
              rows_nxt  = step_out(rows_r, cfg.max_rows);
              state_nxt = S_DIVW_GO;
            end
            tvsz_pkg::OP_TILE: state_nxt = S_TILEX;
            tvsz_pkg::OP_RECT: begin
              vis_nxt   = rect_vis;
              state_nxt = S_RESULT;
            end
            default: state_nxt = S_RESULT;
          endcase
        end
      end
      S_DIVW_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          cell_w_nxt = cell_q;
          state_nxt  = S_DIVH_GO;
        end
      end
      S_DIVH_GO: begin
        div_start = 1'b1;
        div_dvd   = cfg.view_h;
        div_dvs   = (rows_r == '0) ? TW'(1) : rows_r;
        state_nxt = S_DIVH;
      end
      S_DIVH: begin
        if (div_done) begin
          cell_h_nxt = cell_q;
          state_nxt  = item_r ? S_RESULT : S_IDLE;
        end
      end
      S_MAPX: begin
        mul_a     = PW'(cfg.map_cols);
        mul_b     = cell_w_r;
        state_nxt = S_POSX;
      end
      S_POSX: begin
        map_px_nxt = mul_r[MPW-1:0];
        mul_a      = pos_x_r;
        mul_b      = cell_w_r;
        state_nxt  = S_OFFX;
      end
      S_OFFX: begin
        off_x_nxt = centre_axis(cfg.view_w, cell_w_r, map_px_r, mul_r);
        state_nxt = S_MAPY;
      end
      S_MAPY: begin
        mul_a     = PW'(cfg.map_rows);
        mul_b     = cell_h_r;
        state_nxt = S_POSY;
      end
      S_POSY: begin
        map_px_nxt = mul_r[MPW-1:0];
        mul_a      = pos_y_r;
        mul_b      = cell_h_r;
        state_nxt  = S_OFFY;
      end
      S_OFFY: begin
        off_y_nxt = centre_axis(cfg.view_h, cell_h_r, map_px_r, mul_r);
        state_nxt = S_RESULT;
      end
      S_TILEX: begin
        mul_a     = PW'(pos_x_r >> FB);
        mul_b     = cell_w_r;
        state_nxt = S_TILEY;
      end
      S_TILEY: begin
        sx_nxt    = sat24(tile_e);
        vis_x_nxt = tile_vis;
        mul_a     = PW'(pos_y_r >> FB);
        mul_b     = cell_h_r;
        state_nxt = S_TILEF;
      end
      S_TILEF: begin
        sy_nxt    = sat24(tile_e);
        vis_nxt   = vis_x_r && tile_vis;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {1'b0, vis_r, sy_r, sx_r, cell_h_r, cell_w_r,
                           off_y_r[tvsz_pkg::SCROLL_W-1:0], off_x_r[tvsz_pkg::SCROLL_W-1:0]};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a register write asks for a fresh cell size
    if (cfg_wr) recalc_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      item_r      <= 1'b0;
      recalc_r    <= 1'b0;
      cols_r      <= tvsz_pkg::COLS_RST;
      rows_r      <= tvsz_pkg::ROWS_RST;
      cell_w_r    <= tvsz_pkg::CELL_W_RST;
      cell_h_r    <= tvsz_pkg::CELL_H_RST;
      off_x_r     <= '0;
      off_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      item_r      <= item_nxt;
      recalc_r    <= recalc_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      cell_w_r    <= cell_w_nxt;
      cell_h_r    <= cell_h_nxt;
      off_x_r     <= off_x_nxt;
      off_y_r     <= off_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    pos_x_r    <= pos_x_nxt;
    pos_y_r    <= pos_y_nxt;
    map_px_r   <= map_px_nxt;
    mul_r      <= PRW'(mul_a) * PRW'(mul_b);
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    vis_x_r    <= vis_x_nxt;
    vis_r      <= vis_nxt;
  end

endmodule

FILE: bench/tb_top.sv
module tb_top;
  import tvsz_pkg::*;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_MID   = 3'd6;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam int HOLD_LEN = 300;
  localparam int RAND_PER_SETTING = 185;

  typedef struct {
    logic [2:0]         op;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic signed [23:0] rect_x;
    logic signed [23:0] rect_y;
    logic [11:0]        rect_w;
    logic [11:0]        rect_h;
  } view_cmd_t;

  typedef struct {
    logic signed [22:0] scroll_x;
    logic signed [22:0] scroll_y;
    logic [11:0]        cell_w;
    logic [11:0]        cell_h;
    logic signed [23:0] draw_x;
    logic signed [23:0] draw_y;
    logic               visible;
  } view_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tready = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata = '0;
  wire in_tready;
  wire out_tvalid;
  wire [OUT_TDATA_W-1:0] out_tdata;
  wire [APB_DATA_W-1:0] cfg_prdata;
  wire cfg_pready;

  tile_viewport_scroll_zoom uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow of the viewport state
  cfg_t vcfg;
  logic [TILE_W-1:0] cols_now, rows_now;
  logic [11:0] cell_w_now, cell_h_now;
  longint scroll_x_now, scroll_y_now;

  view_cmd_t cmd_q[$];
  view_result_t pending_views[$];
  view_cmd_t cur_cmd;

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int mismatches = 0;
  int stalled_cycles = 0;
  int visible_seen = 0;
  int settings_used = 1;
  int op_seen [8];

  logic hold_on = 1'b0;
  int hold_cycles = 0;
  wire hold_active = hold_on && (hold_cycles < HOLD_LEN);

  function automatic logic [11:0] cell_px(longint view, longint tiles);
    longint q;
    q = view / ((tiles == 0) ? 1 : tiles);
    return (q < 1) ? 12'd1 : 12'(q);
  endfunction

  function automatic void refresh_cells();
    cell_w_now = cell_px(vcfg.view_w, cols_now);
    cell_h_now = cell_px(vcfg.view_h, rows_now);
  endfunction

  function automatic longint centre_offset(longint pos, longint pitch, longint view,
                                           longint tiles);
    longint map_px, want;
    map_px = tiles * pitch;
    // map fits on screen: centre it instead of scrolling
    if (map_px <= view) return (view - map_px) / 2;
    want = view / 2 - ((2 * pos * pitch + (pitch << FRAC_BITS)) >>> (FRAC_BITS + 1));
    if (want < view - map_px) want = view - map_px;
    if (want > 0) want = 0;
    return want;
  endfunction

  function automatic logic [TILE_W-1:0] zoom_in_count(longint n, longint lo);
    longint t;
    t = n - ZOOM_STEP;
    if (t < lo) t = lo;
    if (t < 1) t = 1;
    return TILE_W'(t);
  endfunction

  function automatic logic [TILE_W-1:0] zoom_out_count(longint n, longint hi);
    longint t;
    t = n + ZOOM_STEP;
    if (t > hi) t = hi;
    if (t < 1) t = 1;
    return TILE_W'(t);
  endfunction

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic view_result_t predict_viewport(view_cmd_t c);
    view_result_t r;
    longint vw, vh, cw, ch, ex, ey, rx, ry, rw, rh;
    logic vis;
    vw = vcfg.view_w;
    vh = vcfg.view_h;
    cw = cell_w_now;
    ch = cell_h_now;
    ex = 0;
    ey = 0;
    vis = 1'b0;
    case (c.op)
      OP_CENTRE: begin
        scroll_x_now = centre_offset(c.pos_x, cell_w_now, vcfg.view_w, vcfg.map_cols);
        scroll_y_now = centre_offset(c.pos_y, cell_h_now, vcfg.view_h, vcfg.map_rows);
      end
      OP_ZOOM_IN: begin
        cols_now = zoom_in_count(cols_now, vcfg.min_cols);
        rows_now = zoom_in_count(rows_now, vcfg.min_rows);
        refresh_cells();
      end
      OP_ZOOM_OUT: begin
        cols_now = zoom_out_count(cols_now, vcfg.max_cols);
        rows_now = zoom_out_count(rows_now, vcfg.max_rows);
        refresh_cells();
      end
      OP_TILE: begin
        ex = longint'(c.pos_x >> FRAC_BITS) * cw + scroll_x_now;
        ey = longint'(c.pos_y >> FRAC_BITS) * ch + scroll_y_now;
        vis = (ex + cw > 0) && (ex < vw) && (ey + ch > 0) && (ey < vh);
        ex = sat24(ex);
        ey = sat24(ey);
      end
      OP_RECT: begin
        rx = c.rect_x;
        ry = c.rect_y;
        rw = c.rect_w;
        rh = c.rect_h;
        vis = (rx + rw > 0) && (ry + rh > 0) && (rx < vw) && (ry < vh);
      end
      default: ;
    endcase
    r.scroll_x = 23'(scroll_x_now);
    r.scroll_y = 23'(scroll_y_now);
    r.cell_w = cell_w_now;
    r.cell_h = cell_h_now;
    r.draw_x = 24'(ex);
    r.draw_y = 24'(ey);
    r.visible = vis;
    return r;
  endfunction

  function automatic void queue_item(view_cmd_t c);
    cmd_q.push_back(c);
    beats_sent++;
  endfunction

  function automatic void queue_op(logic [2:0] op, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                   logic [23:0] rx, logic [23:0] ry,
                                   logic [11:0] rw, logic [11:0] rh);
    view_cmd_t c;
    c.op = op;
    c.pos_x = px;
    c.pos_y = py;
    c.rect_x = rx;
    c.rect_y = ry;
    c.rect_w = rw;
    c.rect_h = rh;
    queue_item(c);
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%s mismatch on result %0d: expected %0d, got %0d",
                 name, beats_checked, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_active) hold_cycles <= hold_cycles + 1;
  end

  // driver: one beat per handshake, prediction taken at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        pending_views.push_back(predict_viewport(cur_cmd));
        op_seen[cur_cmd.op]++;
      end
      if (cmd_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        cur_cmd = cmd_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= cur_cmd.op;
        in_tdata <= {4'b0, cur_cmd.rect_h, cur_cmd.rect_w, cur_cmd.rect_y, cur_cmd.rect_x,
                     cur_cmd.pos_y, cur_cmd.pos_x};
      end else begin
        in_tvalid <= 1'b0;
      end
    end else begin
      stalled_cycles++;
    end
  end

  // monitor
  always @(posedge clk) begin
    view_result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.scroll_x = out_tdata[22:0];
        got.scroll_y = out_tdata[45:23];
        got.cell_w = out_tdata[57:46];
        got.cell_h = out_tdata[69:58];
        got.draw_x = out_tdata[93:70];
        got.draw_y = out_tdata[117:94];
        got.visible = out_tdata[118];
        if (got.visible) visible_seen++;
        if (pending_views.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result beat with nothing outstanding: scroll %0d,%0d cell %0d,%0d",
                     got.scroll_x, got.scroll_y, got.cell_w, got.cell_h);
        end else begin
          want = pending_views.pop_front();
          check_field("scroll_x", want.scroll_x, got.scroll_x);
          check_field("scroll_y", want.scroll_y, got.scroll_y);
          check_field("cell_w", want.cell_w, got.cell_w);
          check_field("cell_h", want.cell_h, got.cell_h);
          check_field("draw_x", want.draw_x, got.draw_x);
          check_field("draw_y", want.draw_y, got.draw_y);
          check_field("visible", want.visible, got.visible);
          beats_checked++;
        end
      end
      out_tready <= !hold_active && ($urandom_range(99) >= out_stall_pct);
    end
  end

  initial begin
    logic [31:0] words [8];
    view_cmd_t c;
    int unsigned p, k, pick;
    logic [31:0] junk;

    vcfg.view_w = VIEW_W_RST;
    vcfg.view_h = VIEW_H_RST;
    vcfg.map_cols = MAP_COLS_RST;
    vcfg.map_rows = MAP_ROWS_RST;
    vcfg.min_cols = MIN_COLS_RST;
    vcfg.min_rows = MIN_ROWS_RST;
    vcfg.max_cols = MAX_COLS_RST;
    vcfg.max_rows = MAX_ROWS_RST;
    cols_now = COLS_RST;
    rows_now = ROWS_RST;
    refresh_cells();
    scroll_x_now = 0;
    scroll_y_now = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 73; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 73; end
        default: begin in_idle_pct = 19; out_stall_pct = 19; end
      endcase

      if (p == 0) begin
        // reset settings: corners of the position and rectangle fields, rectangle edges, spare codes
        queue_op(OP_TILE, '0, '0, '0, '0, '0, '0);
        queue_op(OP_TILE, '1, '1, '1, '1, '1, '1);
        queue_op(OP_CENTRE, '0, '0, '0, '0, '0, '0);
        queue_op(OP_CENTRE, '1, '1, '0, '0, '0, '0);
        queue_op(OP_TILE, 18'd99 << FRAC_BITS, 18'd99 << FRAC_BITS, '0, '0, '0, '0);
        queue_op(OP_CENTRE, (18'd50 << FRAC_BITS) | 18'd128, (18'd40 << FRAC_BITS) | 18'd255,
                 '0, '0, '0, '0);
        queue_op(OP_RECT, '0, '0, 24'h800000, 24'h800000, 12'hFFF, 12'hFFF);
        queue_op(OP_RECT, '0, '0, 24'h7FFFFF, 24'h7FFFFF, 12'hFFF, 12'hFFF);
        queue_op(OP_RECT, '0, '0, '0, '0, '0, '0);
        queue_op(OP_RECT, '0, '0, -24'sd10, -24'sd10, 12'd11, 12'd11);
        queue_op(OP_RECT, '0, '0, -24'sd10, -24'sd10, 12'd10, 12'd10);
        queue_op(OP_RECT, '0, '0, 24'd639, 24'd479, 12'd1, 12'd1);
        queue_op(OP_RECT, '0, '0, 24'd640, 24'd0, 12'd5, 12'd5);
        queue_op(OP_SPARE_FIRST, '1, '1, '1, '1, '1, '1);
        queue_op(OP_SPARE_MID, 18'h2AAAA, 18'h15555, 24'h555555, 24'hAAAAAA, 12'h5A5, 12'hA5A);
        queue_op(OP_SPARE_LAST, '0, '0, '0, '0, '0, '0);
        // walk down to the zoom-in floor (and past it for rows), then step back out
        repeat (6) queue_op(OP_ZOOM_IN, '0, '0, '0, '0, '0, '0);
        repeat (2) queue_op(OP_ZOOM_OUT, '0, '0, '0, '0, '0, '0);
        queue_op(OP_TILE, 18'd3 << FRAC_BITS, 18'd2 << FRAC_BITS, '0, '0, '0, '0);
      end else begin
        case (p)
          1: words = '{4095, 4095, 1023, 1023, 1, 1, 1023, 1023};
          2: words = '{1, 1, 1, 1, 1, 1, 1, 1};
          3: words = '{0, 0, 0, 0, 0, 0, 0, 0};
          // small map with crossed zoom bounds
          4: words = '{800, 600, 8, 6, 30, 25, 10, 9};
          default: begin
            for (k = 0; k < 8; k++) begin
              words[k] = (k < 2) ? $urandom_range(1, 4095) :
                         (k < 4) ? $urandom_range(1, 1023) : $urandom_range(1, 60);
              junk = $urandom & ((k < 2) ? 32'hFFFFF000 : 32'hFFFFFC00);
              if ($urandom_range(1) == 1) words[k] = words[k] | junk;
            end
          end
        endcase
        for (k = 0; k < 8; k++) begin
          @(posedge clk);
          cfg_psel <= 1'b1;
          cfg_penable <= 1'b0;
          cfg_pwrite <= 1'b1;
          cfg_paddr <= {3'(k), 2'b00};
          cfg_pwdata <= words[k];
          @(posedge clk);
          cfg_penable <= 1'b1;
          @(posedge clk);
          while (!cfg_pready) @(posedge clk);
          cfg_psel <= 1'b0;
          cfg_penable <= 1'b0;
          cfg_pwrite <= 1'b0;
          case (3'(k))
            REG_VIEW_W:   vcfg.view_w = words[k][11:0];
            REG_VIEW_H:   vcfg.view_h = words[k][11:0];
            REG_MAP_COLS: vcfg.map_cols = words[k][9:0];
            REG_MAP_ROWS: vcfg.map_rows = words[k][9:0];
            REG_MIN_COLS: vcfg.min_cols = words[k][9:0];
            REG_MIN_ROWS: vcfg.min_rows = words[k][9:0];
            REG_MAX_COLS: vcfg.max_cols = words[k][9:0];
            default:      vcfg.max_rows = words[k][9:0];
          endcase
          refresh_cells();
          // let the cell recompute finish before the next write
          @(posedge clk);
          while (!in_tready) @(posedge clk);
        end
        settings_used++;
      end

      // sender keeps offering while the receiver is held off
      if (p == 4) hold_on = 1'b1;

      for (k = 0; k < RAND_PER_SETTING; k++) begin
        pick = $urandom_range(99);
        c.op = (pick < 20) ? OP_CENTRE :
               (pick < 35) ? OP_ZOOM_IN :
               (pick < 50) ? OP_ZOOM_OUT :
               (pick < 75) ? OP_TILE :
               (pick < 95) ? OP_RECT : 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        if ($urandom_range(3) == 0) begin
          c.pos_x = 18'($urandom);
          c.pos_y = 18'($urandom);
        end else begin
          c.pos_x = {10'($urandom_range(vcfg.map_cols)), 8'($urandom)};
          c.pos_y = {10'($urandom_range(vcfg.map_rows)), 8'($urandom)};
        end
        if ($urandom_range(3) == 0) begin
          c.rect_x = 24'($urandom);
          c.rect_y = 24'($urandom);
        end else begin
          c.rect_x = 24'(int'($urandom_range(8191)) - 4096);
          c.rect_y = 24'(int'($urandom_range(8191)) - 4096);
        end
        c.rect_w = 12'($urandom);
        c.rect_h = 12'($urandom);
        queue_item(c);
      end

      while (beats_checked != beats_sent) @(posedge clk);
      repeat (8) @(posedge clk);
    end

    repeat (40) @(posedge clk);
    $display("run covered %0d beats over %0d register settings: centre %0d, zoom %0d,",
             beats_checked, settings_used, op_seen[OP_CENTRE],
             op_seen[OP_ZOOM_IN] + op_seen[OP_ZOOM_OUT]);
    $display("tile %0d, rect %0d, spare codes %0d, visible results %0d, stalled offers %0d",
             op_seen[OP_TILE], op_seen[OP_RECT],
             op_seen[OP_SPARE_FIRST] + op_seen[OP_SPARE_MID] + op_seen[OP_SPARE_LAST],
             visible_seen, stalled_cycles);
    if (mismatches == 0 && pending_views.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
